[src/nhst_pkg.sv]
package nhst_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 24;
  localparam int MU_BITS   = 31;
  localparam int NU_BITS   = 23;
  localparam int CFG_BITS  = 32;

  // divider: quotient bits resolved per stage and number of stages
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = WORD_BITS / DIV_STEPS;
  localparam int DIV_LAT    = DIV_STAGES + 2;

  typedef logic signed [WORD_BITS-1:0]   word_t;
  typedef logic signed [2*WORD_BITS-1:0] prod_t;

  typedef struct packed {
    logic  clip;
    word_t val;
  } sat_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t ONE_Q    = word_t'(1) <<< FRAC_BITS;
  localparam word_t HALF_Q   = word_t'(1) <<< (FRAC_BITS - 1);
  localparam prod_t HALF_P   = prod_t'(1) <<< (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    REG_MU     = 3'd0,
    REG_PRE_XX = 3'd1,
    REG_PRE_XY = 3'd2,
    REG_PRE_YX = 3'd3,
    REG_PRE_YY = 3'd4
  } reg_idx_t;

  typedef struct packed {
    word_t               grad_xx;
    word_t               grad_xy;
    word_t               grad_yx;
    word_t               grad_yy;
    logic [NU_BITS-1:0]  poisson_ratio;
  } in_item_t;

  typedef struct packed {
    logic [1:0] entry_index;
    word_t      stress_value;
    word_t      modulus_k0_l0;
    word_t      modulus_k0_l1;
    word_t      modulus_k1_l0;
    word_t      modulus_k1_l1;
    logic       singular_flag;
    logic       saturated_flag;
    logic       last_of_item;
  } out_item_t;

  typedef struct packed {
    word_t       mu;
    word_t [3:0] pre;
  } cfg_t;

  // per material point values, index 2*row+col
  typedef struct packed {
    word_t [3:0] f;
    word_t [3:0] fi;
    word_t       c1;
    word_t       c2;
    logic        clip;
    logic        singular;
  } item_t;

  function automatic sat_t sat_word(input logic [WORD_BITS:0] s);
    sat_t r;
    r.clip = s[WORD_BITS] ^ s[WORD_BITS-1];
    r.val  = r.clip ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : word_t'(s[WORD_BITS-1:0]);
    return r;
  endfunction

  function automatic sat_t sat_add(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    return sat_word(s);
  endfunction

  function automatic sat_t sat_sub(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    return sat_word(s);
  endfunction

  function automatic prod_t smul(input word_t a, input word_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  // round to nearest on the magnitude, ties away from zero, then clamp
  function automatic sat_t mul_round(input prod_t p);
    prod_t t;
    sat_t  r;
    logic  ovf;
    t   = (p + (p[2*WORD_BITS-1] ? (HALF_P - prod_t'(1)) : HALF_P)) >>> FRAC_BITS;
    ovf = !((&t[2*WORD_BITS-1:WORD_BITS-1]) || !(|t[2*WORD_BITS-1:WORD_BITS-1]));
    r.clip = ovf;
    r.val  = ovf ? (t[2*WORD_BITS-1] ? WORD_MIN : WORD_MAX) : word_t'(t[WORD_BITS-1:0]);
    return r;
  endfunction

endpackage

[src/nhst_div.sv]
module nhst_div
  import nhst_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  word_t a,
  input  word_t b,
  output word_t q,
  output logic  clip
);

  localparam int SH = WORD_BITS - FRAC_BITS;

  typedef struct packed {
    logic [WORD_BITS-1:0] rem;
    logic [WORD_BITS-1:0] quo;
    logic [WORD_BITS-1:0] nlo;
    logic [WORD_BITS-1:0] ub;
    logic                 neg;
    logic                 bzero;
    logic                 azero;
    logic                 ovf;
  } dstage_t;

  dstage_t st_r [DIV_STAGES+1];
  dstage_t st0_nxt;
  word_t   q_r, q_nxt;
  logic    clip_r, clip_nxt;

  always_comb begin
    logic [WORD_BITS-1:0] ua;
    logic [WORD_BITS-1:0] ub;
    ua = a[WORD_BITS-1] ? (~a + 1'b1) : a;
    ub = b[WORD_BITS-1] ? (~b + 1'b1) : b;
    st0_nxt.rem   = ua >> SH;
    st0_nxt.quo   = '0;
    st0_nxt.nlo   = {ua[SH-1:0], {FRAC_BITS{1'b0}}};
    st0_nxt.ub    = ub;
    st0_nxt.neg   = a[WORD_BITS-1] ^ b[WORD_BITS-1];
    st0_nxt.bzero = (b == '0);
    st0_nxt.azero = (a == '0);
    // quotient reaches 2^WORD_BITS
    st0_nxt.ovf   = ({{SH{1'b0}}, ua} >= {ub, {SH{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st0_nxt;
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    dstage_t st_nxt;
    always_comb begin
      logic [WORD_BITS:0] r2;
      st_nxt = st_r[s];
      for (int k = 0; k < DIV_STEPS; k++) begin
        r2 = {st_nxt.rem, st_nxt.nlo[WORD_BITS-1]};
        st_nxt.nlo = st_nxt.nlo << 1;
        if (r2 >= {1'b0, st_nxt.ub}) begin
          r2 = r2 - {1'b0, st_nxt.ub};
          st_nxt.quo = {st_nxt.quo[WORD_BITS-2:0], 1'b1};
        end else begin
          st_nxt.quo = {st_nxt.quo[WORD_BITS-2:0], 1'b0};
        end
        st_nxt.rem = r2[WORD_BITS-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[s+1] <= st_nxt;
      end
    end
  end

  always_comb begin
    dstage_t            f;
    logic               rnd;
    logic [WORD_BITS:0] qq;
    logic [WORD_BITS:0] lim;
    logic [WORD_BITS:0] mg;
    f   = st_r[DIV_STAGES];
    rnd = ({f.rem, 1'b0} >= {1'b0, f.ub});
    qq  = {1'b0, f.quo} + {{WORD_BITS{1'b0}}, rnd};
    lim = {2'b00, {(WORD_BITS-1){1'b1}}} + {{WORD_BITS{1'b0}}, f.neg};
    mg  = qq;
    clip_nxt = 1'b0;
    if (f.ovf || (qq > lim)) begin
      clip_nxt = 1'b1;
      mg       = lim;
    end
    q_nxt = f.neg ? word_t'(~mg[WORD_BITS-1:0] + 1'b1) : word_t'(mg[WORD_BITS-1:0]);
    if (f.bzero) begin
      clip_nxt = 1'b1;
      q_nxt    = f.azero ? '0 : (f.neg ? WORD_MIN : WORD_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r    <= q_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign q    = q_r;
  assign clip = clip_r;

endmodule

[src/nhst_item.sv]
module nhst_item
  import nhst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_valid,
  input  in_item_t in_data,
  input  cfg_t     cfg,
  output logic     item_valid,
  output item_t    item
);

  localparam int NST = 5 + DIV_LAT + 4;

  logic [NST-1:0] v_r;

  // s0: input register
  in_item_t s0_r;
  // s1: deformation gradient
  word_t [3:0] f1_r;
  word_t       nu1_r;
  logic        clip1_r;
  // s2: raw products
  word_t [3:0] f2_r;
  prod_t       p00_r, p01_r, pmn_r;
  word_t       omn2_r, adj01_2_r, adj10_2_r;
  logic        clip2_r;
  // s3: rounded products
  word_t [3:0] f3_r;
  word_t       m0_r, m1_r, mnu3_r, omn3_r, adj01_3_r, adj10_3_r;
  logic        clip3_r;
  // s4: determinant
  word_t [3:0] f4_r, adj4_r;
  word_t       det4_r, mnu4_r, omn4_r;
  logic        sing4_r, clip4_r;

  typedef struct packed {
    word_t [3:0] f;
    word_t       det;
    logic        singular;
    logic        clip;
  } side_t;

  side_t side_r [DIV_LAT];

  word_t [3:0] fi_q;
  logic  [3:0] fi_clip;
  word_t       r_q;
  logic        r_clip;

  // post-divider stages
  word_t [3:0] f5_r, fi5_r;
  word_t       det5_r, r2_5_r, r4_5_r;
  prod_t       j2p_r, dhp_r;
  logic        sing5_r, clip5_r;

  word_t [3:0] f6_r, fi6_r;
  word_t       r2_6_r, r4_6_r, jd_r, jh_r;
  logic        sing6_r, clip6_r;

  word_t [3:0] f7_r, fi7_r;
  prod_t       pa_r, pb_r;
  logic        sing7_r, clip7_r;

  item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= in_data;
    end
  end

  // s1
  always_ff @(posedge clk) begin
    word_t [3:0] g;
    sat_t        s;
    logic        c;
    if (en) begin
      g = {s0_r.grad_yy, s0_r.grad_yx, s0_r.grad_xy, s0_r.grad_xx};
      c = 1'b0;
      for (int e = 0; e < 4; e++) begin
        s = sat_add(cfg.pre[e], g[e]);
        f1_r[e] <= s.val;
        c = c | s.clip;
      end
      nu1_r   <= word_t'({{(WORD_BITS-NU_BITS){1'b0}}, s0_r.poisson_ratio});
      clip1_r <= c;
    end
  end

  // s2
  always_ff @(posedge clk) begin
    sat_t so, sa, sb;
    if (en) begin
      so = sat_sub(ONE_Q, nu1_r);
      sa = sat_sub('0, f1_r[1]);
      sb = sat_sub('0, f1_r[2]);
      f2_r      <= f1_r;
      p00_r     <= smul(f1_r[0], f1_r[3]);
      p01_r     <= smul(f1_r[1], f1_r[2]);
      pmn_r     <= smul(cfg.mu, nu1_r);
      omn2_r    <= so.val;
      adj01_2_r <= sa.val;
      adj10_2_r <= sb.val;
      clip2_r   <= clip1_r | so.clip | sa.clip | sb.clip;
    end
  end

  // s3
  always_ff @(posedge clk) begin
    sat_t a, b, c;
    if (en) begin
      a = mul_round(p00_r);
      b = mul_round(p01_r);
      c = mul_round(pmn_r);
      f3_r      <= f2_r;
      m0_r      <= a.val;
      m1_r      <= b.val;
      mnu3_r    <= c.val;
      omn3_r    <= omn2_r;
      adj01_3_r <= adj01_2_r;
      adj10_3_r <= adj10_2_r;
      clip3_r   <= clip2_r | a.clip | b.clip | c.clip;
    end
  end

  // s4
  always_ff @(posedge clk) begin
    sat_t d;
    if (en) begin
      d = sat_sub(m0_r, m1_r);
      f4_r    <= f3_r;
      adj4_r  <= {f3_r[0], adj10_3_r, adj01_3_r, f3_r[3]};
      det4_r  <= d.val;
      sing4_r <= (d.val == '0);
      mnu4_r  <= mnu3_r;
      omn4_r  <= omn3_r;
      clip4_r <= clip3_r | d.clip;
    end
  end

  for (genvar e = 0; e < 4; e++) begin : g_inv
    nhst_div u_div (
      .clk  (clk),
      .en   (en),
      .a    (adj4_r[e]),
      .b    (det4_r),
      .q    (fi_q[e]),
      .clip (fi_clip[e])
    );
  end

  nhst_div u_div_r (
    .clk  (clk),
    .en   (en),
    .a    (mnu4_r),
    .b    (omn4_r),
    .q    (r_q),
    .clip (r_clip)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= '{f: f4_r, det: det4_r, singular: sing4_r, clip: clip4_r};
      for (int k = 1; k < DIV_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // s5: doubled ratio terms, det products
  always_ff @(posedge clk) begin
    side_t sd;
    sat_t  a2, a4;
    if (en) begin
      sd = side_r[DIV_LAT-1];
      a2 = sat_add(r_q, r_q);
      a4 = sat_add(a2.val, a2.val);
      f5_r    <= sd.f;
      fi5_r   <= fi_q;
      det5_r  <= sd.det;
      r2_5_r  <= a2.val;
      r4_5_r  <= a4.val;
      j2p_r   <= smul(sd.det, sd.det);
      dhp_r   <= smul(sd.det, HALF_Q);
      sing5_r <= sd.singular;
      // divider clips of the inverse entries are ignored for a singular point
      clip5_r <= sd.clip | r_clip | a2.clip | a4.clip | (!sd.singular && (|fi_clip));
    end
  end

  // s6
  always_ff @(posedge clk) begin
    sat_t j2, dh, jd, jh;
    if (en) begin
      j2 = mul_round(j2p_r);
      dh = mul_round(dhp_r);
      jd = sat_sub(j2.val, det5_r);
      jh = sat_sub(j2.val, dh.val);
      f6_r    <= f5_r;
      fi6_r   <= fi5_r;
      r2_6_r  <= r2_5_r;
      r4_6_r  <= r4_5_r;
      jd_r    <= jd.val;
      jh_r    <= jh.val;
      sing6_r <= sing5_r;
      clip6_r <= clip5_r | j2.clip | dh.clip | jd.clip | jh.clip;
    end
  end

  // s7
  always_ff @(posedge clk) begin
    if (en) begin
      f7_r    <= f6_r;
      fi7_r   <= fi6_r;
      pa_r    <= smul(r2_6_r, jd_r);
      pb_r    <= smul(r4_6_r, jh_r);
      sing7_r <= sing6_r;
      clip7_r <= clip6_r;
    end
  end

  // s8: coefficients
  always_ff @(posedge clk) begin
    sat_t ta, c1, c2;
    if (en) begin
      ta = mul_round(pa_r);
      c1 = sat_sub(cfg.mu, ta.val);
      c2 = mul_round(pb_r);
      item_r.f        <= f7_r;
      item_r.fi       <= fi7_r;
      item_r.c1       <= c1.val;
      item_r.c2       <= c2.val;
      item_r.singular <= sing7_r;
      item_r.clip     <= clip7_r | ta.clip | c1.clip | c2.clip;
    end
  end

  assign item_valid = v_r[NST-1];
  assign item       = item_r;

endmodule

[src/nhst_entry.sv]
module nhst_entry
  import nhst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  item_t     item,
  input  logic [1:0] idx,
  input  word_t     mu,
  output logic      out_valid,
  output out_item_t out_data
);

  logic [4:0] v_r;

  prod_t       mf1_r;
  prod_t [1:0] a1_r;
  prod_t [3:0] b1_r;
  word_t [1:0] fil1_r;
  word_t       fiji1_r;
  logic [1:0]  idx1_r;
  logic        clip1_r, sing1_r;

  word_t       p2_r;
  word_t [1:0] a2_r;
  word_t [3:0] b2_r;
  word_t [1:0] fil2_r;
  word_t       fiji2_r;
  logic [1:0]  idx2_r;
  logic        clip2_r, sing2_r;

  prod_t [3:0] x3_r, y3_r;
  word_t       p3_r;
  logic [1:0]  idx3_r;
  logic        clip3_r, sing3_r;

  word_t [3:0] x4_r, y4_r;
  word_t       p4_r;
  logic [1:0]  idx4_r;
  logic        clip4_r, sing4_r;

  out_item_t   out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  // b1: first products
  always_ff @(posedge clk) begin
    logic i, j;
    if (en) begin
      i = idx[1];
      j = idx[0];
      mf1_r <= smul(mu, item.f[idx]);
      for (int k = 0; k < 2; k++) begin
        a1_r[k]   <= smul(item.c1, item.fi[{j, 1'(k)}]);
        fil1_r[k] <= item.fi[{1'(k), i}];
      end
      for (int lk = 0; lk < 4; lk++) begin
        b1_r[lk] <= smul(item.c2, item.fi[lk]);
      end
      fiji1_r <= item.fi[{j, i}];
      idx1_r  <= idx;
      clip1_r <= item.clip;
      sing1_r <= item.singular;
    end
  end

  // b2: round, stress
  always_ff @(posedge clk) begin
    sat_t mr, ar0, ar1, br, ps;
    logic c;
    if (en) begin
      mr  = mul_round(mf1_r);
      ar0 = mul_round(a1_r[0]);
      ar1 = mul_round(a1_r[1]);
      ps  = sat_sub(mr.val, idx1_r[1] ? ar1.val : ar0.val);
      c   = clip1_r | mr.clip | ar0.clip | ar1.clip | ps.clip;
      for (int lk = 0; lk < 4; lk++) begin
        br = mul_round(b1_r[lk]);
        b2_r[lk] <= br.val;
        c = c | br.clip;
      end
      p2_r    <= ps.val;
      a2_r    <= {ar1.val, ar0.val};
      fil2_r  <= fil1_r;
      fiji2_r <= fiji1_r;
      idx2_r  <= idx1_r;
      clip2_r <= c;
      sing2_r <= sing1_r;
    end
  end

  // b3: second products, index 2*k+l
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        for (int l = 0; l < 2; l++) begin
          x3_r[2*k+l] <= smul(a2_r[k], fil2_r[l]);
          y3_r[2*k+l] <= smul(b2_r[2*l+k], fiji2_r);
        end
      end
      p3_r    <= p2_r;
      idx3_r  <= idx2_r;
      clip3_r <= clip2_r;
      sing3_r <= sing2_r;
    end
  end

  // b4
  always_ff @(posedge clk) begin
    sat_t xr, yr;
    logic c;
    if (en) begin
      c = clip3_r;
      for (int kl = 0; kl < 4; kl++) begin
        xr = mul_round(x3_r[kl]);
        yr = mul_round(y3_r[kl]);
        x4_r[kl] <= xr.val;
        y4_r[kl] <= yr.val;
        c = c | xr.clip | yr.clip;
      end
      p4_r    <= p3_r;
      idx4_r  <= idx3_r;
      clip4_r <= c;
      sing4_r <= sing3_r;
    end
  end

  // b5: sums and output register
  always_ff @(posedge clk) begin
    sat_t        s1, s2;
    word_t [3:0] cm;
    logic        c;
    if (en) begin
      c = clip4_r;
      for (int kl = 0; kl < 4; kl++) begin
        s1 = sat_add((kl == int'(idx4_r)) ? mu : '0, x4_r[kl]);
        s2 = sat_add(s1.val, y4_r[kl]);
        cm[kl] = s2.val;
        c = c | s1.clip | s2.clip;
      end
      out_r.entry_index    <= idx4_r;
      out_r.stress_value   <= sing4_r ? '0 : p4_r;
      out_r.modulus_k0_l0  <= sing4_r ? '0 : cm[0];
      out_r.modulus_k0_l1  <= sing4_r ? '0 : cm[1];
      out_r.modulus_k1_l0  <= sing4_r ? '0 : cm[2];
      out_r.modulus_k1_l1  <= sing4_r ? '0 : cm[3];
      out_r.singular_flag  <= sing4_r;
      out_r.saturated_flag <= !sing4_r && c;
      out_r.last_of_item   <= (idx4_r == 2'd3);
    end
  end

  assign out_valid = v_r[4];
  assign out_data  = out_r;

endmodule

[src/neo_hookean_stress_tangent_2d_unit.sv]
// each input transfer yields four results; after its first result the other three follow
// throughput is set by the four results per point leaving the single output register
//   one per cycle while out_stall is low
// the item pipeline (including the 8-stage quotient dividers) advances in lock step
// reset: synchronous active-low rst_n clears valid bits and loads default registers
module neo_hookean_stress_tangent_2d_unit
  import nhst_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);

  // configuration registers
  logic [MU_BITS-1:0] mu_r;
  word_t [3:0]        pre_r;
  cfg_t               cfg;

  // item pipeline
  logic  item_valid;
  item_t item;
  logic  en_f;

  // serialiser: one point becomes four entries
  logic       ser_valid_r;
  logic [1:0] ser_cnt_r;
  item_t      ser_item_r;
  logic       ser_load;
  logic       en_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r  <= ONE_Q[MU_BITS-1:0];
      pre_r <= {ONE_Q, word_t'(0), word_t'(0), ONE_Q};
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_MU:     mu_r     <= cfg_data[MU_BITS-1:0];
        REG_PRE_XX: pre_r[0] <= word_t'(cfg_data);
        REG_PRE_XY: pre_r[1] <= word_t'(cfg_data);
        REG_PRE_YX: pre_r[2] <= word_t'(cfg_data);
        REG_PRE_YY: pre_r[3] <= word_t'(cfg_data);
        default: ;
      endcase
    end
  end

  assign cfg.mu  = word_t'({{(WORD_BITS-MU_BITS){1'b0}}, mu_r});
  assign cfg.pre = pre_r;

  // result side moves whenever the output register is empty or being drained
  assign en_b     = !out_valid || !out_stall;
  // a new point enters the serialiser when it is empty or on its last entry
  assign ser_load = en_b && (!ser_valid_r || (ser_cnt_r == 2'd3));
  // item pipeline holds while its finished point waits for the serialiser
  assign en_f     = !item_valid || ser_load;
  assign in_stall = !en_f;

  nhst_item u_item (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en_f),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
      ser_cnt_r   <= 2'd0;
    end else if (ser_load) begin
      ser_valid_r <= item_valid;
      ser_cnt_r   <= 2'd0;
      ser_item_r  <= item;
    end else if (en_b) begin
      ser_cnt_r   <= ser_cnt_r + 2'd1;
    end
  end

  nhst_entry u_entry (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en_b),
    .in_valid  (ser_valid_r),
    .item      (ser_item_r),
    .idx       (ser_cnt_r),
    .mu        (cfg.mu),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // entries of one point leave back to back and in order
  a_entry_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last_of_item) |=>
      (out_valid && (out_data.entry_index == $past(out_data.entry_index) + 2'd1)))
    else $error("entry order broken");

  // a singular point carries zero values and no clip
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.singular_flag) |->
      (!out_data.saturated_flag && (out_data.stress_value == '0)))
    else $error("singular result not cleared");

  // input is only held back by a finished point that cannot move on:
  // either the serialiser is busy or the result side is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (item_valid && (ser_valid_r || out_stall)))
    else $error("input stalled without cause");

  // serialiser counter only leaves zero while it holds a point
  a_ser_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ser_cnt_r != 2'd0) |-> ser_valid_r)
    else $error("serialiser counting while empty");
`endif

endmodule
